// ===== hw/rtl/sidta_pkg.sv =====
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sidta_pkg;

  // Input word and output character sizes
  localparam int unsigned NumW     = 16;
  localparam int unsigned CharW    = 6;
  localparam int unsigned FieldLen = 6;
  localparam int unsigned Digits   = 5;
  localparam int unsigned BcdW     = 4 * Digits;
  localparam int unsigned CntW     = $clog2(NumW);
  localparam int unsigned OutW     = ((CharW * FieldLen + 7) / 8) * 8;

  // Character codes, low six bits of ASCII
  localparam logic [CharW-1:0] CharSpace = 6'd32;
  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StConv = 3'b010,
    StFmt  = 3'b100
  } state_e;

endpackage

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Formats a signed 16-bit integer as six right-justified ASCII characters.
// ----------------------------------------------------------------------------
// Each input beat passes from acceptance into the output register through
// a shift-add-3 binary to BCD converter (one magnitude bit per cycle
// through a single shared digit adjust and shift unit) and then a step
// that blanks leading zeros and places the minus sign. The input is not
// ready while a conversion runs; it is ready again the cycle after the
// load, so a new beat is taken only once the last one is loaded.
// A finished result waits in the output register while the next beat is
// taken; if it has still not left when the next conversion ends,
// formatting holds until the output register frees up. Characters are the
// low six bits of their ASCII codes (space 32, minus 45, digits 48..57);
// -32768 prints in full with the sign leftmost.
module signed_int_to_decimal_ascii (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  logic [sidta_pkg::NumW-1:0] s_axis_tdata_i,  // [15:0] number
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // [5:0] char_0, [11:6] char_1, [17:12] char_2, [23:18] char_3,
  // [29:24] char_4, [35:30] char_5, upper bits zero
  output logic [sidta_pkg::OutW-1:0] m_axis_tdata_o
);
  import sidta_pkg::*;

  state_e                state_q, state_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [NumW-1:0]       mag_q, mag_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  logic [OutW-1:0]       out_data_q, out_data_d;

  logic                  in_beat;
  logic                  out_free;
  logic [BcdW-1:0]       bcd_adj;
  logic [BcdW+NumW-1:0]  shifted;
  logic [FieldLen-1:0]   show;
  logic [CharW-1:0]      chars [FieldLen];
  logic [OutW-1:0]       fmt_data;

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_beat         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Add 3 to every digit of five or more, then shift one bit in
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
    shifted = {bcd_adj, mag_q} << 1;
  end

  // Blank leading zeros and place the sign next to the first digit
  always_comb begin
    logic seen;
    logic [3:0] dig;
    logic [BcdW+3:0] bcd_ext;
    // Pad a zero digit on top so the leftmost slot indexes in range
    bcd_ext = {4'd0, bcd_q};
    seen    = 1'b0;
    show[0] = 1'b0;
    for (int j = 1; j < FieldLen; j++) begin
      dig     = bcd_ext[4*(FieldLen-1-j) +: 4];
      seen    = seen | (dig != 4'd0);
      show[j] = seen | (j == FieldLen - 1);
    end
    for (int j = 0; j < FieldLen; j++) begin
      if (show[j]) begin
        chars[j] = CharZero + {2'b00, bcd_ext[4*(FieldLen-1-j) +: 4]};
      end else if (neg_q && (j < FieldLen - 1) && show[(j+1) % FieldLen]) begin
        chars[j] = CharMinus;
      end else begin
        chars[j] = CharSpace;
      end
    end
    fmt_data = '0;
    for (int j = 0; j < FieldLen; j++) begin
      fmt_data[CharW*j +: CharW] = chars[j];
    end
  end

  // Sequencer: load, convert bit by bit, format into the output register
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_data_d  = out_data_q;
    unique case (state_q)
      StIdle: begin
        if (in_beat) begin
          neg_d   = s_axis_tdata_i[NumW-1];
          mag_d   = s_axis_tdata_i[NumW-1] ? (~s_axis_tdata_i + 1'b1) : s_axis_tdata_i;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = StConv;
        end
      end
      StConv: begin
        bcd_d = shifted[NumW +: BcdW];
        mag_d = shifted[NumW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          state_d = StFmt;
        end
      end
      StFmt: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = fmt_data;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    neg_q      <= neg_d;
    out_data_q <= out_data_d;
  end

endmodule
